>>> rtl/rpv_pkg.sv
// Shared types, constants and codes of the relative path validator.
package rpv_pkg;

  // Counter and length widths fixed by the field widths
  localparam int unsigned CntW = 13;
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
  localparam int unsigned RootW = 7;
  localparam int unsigned NeedW = CntW + 1;
  localparam int unsigned SufLenW = 4;

  // Depth of the queue between front and back
  localparam int unsigned QDepth = 2;

  // Configuration register indexes
  localparam logic [2:0] CFG_GRANTED    = 3'd0;
  localparam logic [2:0] CFG_MEDIA      = 3'd1;
  localparam logic [2:0] CFG_ROOT_LEN   = 3'd2;
  localparam logic [2:0] CFG_CAPACITY   = 3'd3;
  localparam logic [2:0] CFG_SUFFIX     = 3'd4;
  localparam logic [2:0] CFG_SUFFIX_LEN = 3'd5;

  // Media state meaning ready
  localparam logic [1:0] MEDIA_READY = 2'd1;

  // Capacity after reset
  localparam logic [CntW-1:0] CapacityReset = 13'd256;

  // Bytes with special meaning in a path
  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_DOT       = 8'h2e;
  localparam logic [7:0] CH_NUL       = 8'h00;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_GRANT     = 3'd1,
    ST_DISCONNECTED = 3'd2,
    ST_INVALID      = 3'd3,
    ST_TOO_LONG     = 3'd4
  } status_e;

  // One finished path handed from front to back
  typedef struct packed {
    logic            empty;
    logic            invalid;
    logic [CntW-1:0] count;
  } job_t;

  // Registers that the back end checks against
  typedef struct packed {
    logic             granted;
    logic [1:0]       media;
    logic [RootW-1:0] root_len;
    logic [CntW-1:0]  capacity;
  } grant_cfg_t;

endpackage

>>> rtl/relative_path_validator.sv
// Top level of the relative path validator: configuration registers and the two halves.
//
// Use: a relative path enters one byte per beat on the input channel (in_valid_i,
// in_stall_o, path_byte_i, last_i, empty_path_i); the beat with last_i set, or a
// single beat with empty_path_i set, closes the path. Each closed path gives one
// result beat on the output channel (out_valid_o, out_stall_i, status_o,
// built_length_o); other bytes give none.
// Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_wdata_i), to be
// written only while no path is in flight.
// Throughput: one byte per cycle while in_stall_o is low, since the front end updates
// its component tracking as each byte is accepted. A result beat passes through the
// queue and then the output register before it is valid; while the output register
// is held by a stall, it waits in the queue.
// When the receiver stalls, the result beat holds; the queue takes further
// closing bytes until it is full, then in_stall_o rises.
// Reset clears the path state, the queue and the output; registers return to
// zero except the capacity register, which returns to 256.
module relative_path_validator #(
  parameter int unsigned MAX_PATH     = 256,
  parameter int unsigned SUFFIX_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  path_byte_i,
  input  logic        last_i,
  input  logic        empty_path_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [12:0] built_length_o
);

  logic                        granted_q;
  logic [1:0]                  media_q;
  logic [rpv_pkg::RootW-1:0]   root_len_q;
  logic [rpv_pkg::CntW-1:0]    capacity_q;
  logic [63:0]                 suffix_q;
  logic [rpv_pkg::SufLenW-1:0] suffix_len_q;

  rpv_pkg::grant_cfg_t grant_cfg;
  rpv_pkg::job_t       push_job;
  rpv_pkg::job_t       head_job;
  logic                accept;
  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_empty;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      granted_q    <= 1'b0;
      media_q      <= '0;
      root_len_q   <= '0;
      capacity_q   <= rpv_pkg::CapacityReset;
      suffix_q     <= '0;
      suffix_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rpv_pkg::CFG_GRANTED:    granted_q    <= cfg_wdata_i[0];
        rpv_pkg::CFG_MEDIA:      media_q      <= cfg_wdata_i[1:0];
        rpv_pkg::CFG_ROOT_LEN:   root_len_q   <= cfg_wdata_i[rpv_pkg::RootW-1:0];
        rpv_pkg::CFG_CAPACITY:   capacity_q   <= cfg_wdata_i[rpv_pkg::CntW-1:0];
        rpv_pkg::CFG_SUFFIX:     suffix_q     <= cfg_wdata_i;
        rpv_pkg::CFG_SUFFIX_LEN: suffix_len_q <= cfg_wdata_i[rpv_pkg::SufLenW-1:0];
        default: ;
      endcase
    end
  end

  assign grant_cfg.granted  = granted_q;
  assign grant_cfg.media    = media_q;
  assign grant_cfg.root_len = root_len_q;
  assign grant_cfg.capacity = capacity_q;

  // Stall the input only when the queue has no room
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  rpv_front #(
    .SUFFIX_BYTES (SUFFIX_BYTES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .path_byte_i     (path_byte_i),
    .last_i          (last_i),
    .empty_path_i    (empty_path_i),
    .temp_suffix_i   (suffix_q),
    .suffix_length_i (suffix_len_q),
    .push_o          (push),
    .job_o           (push_job)
  );

  rpv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .pop_i   (pop),
    .rdata_o (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  rpv_back #(
    .MAX_PATH (MAX_PATH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (grant_cfg),
    .job_valid_i    (!q_empty),
    .job_i          (head_job),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .built_length_o (built_length_o)
  );

`ifndef SYNTHESIS
  // A valid result beat carries a length exactly when it is ok
  a_ok_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == rpv_pkg::ST_OK)) |-> (built_length_o != '0))
    else $error("ok result with zero length");

  a_fail_no_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != rpv_pkg::ST_OK)) |-> (built_length_o == '0))
    else $error("failed result with non-zero length");

  // The back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("pop from empty queue");
`endif

endmodule

>>> rtl/rpv_front.sv
// Front end: takes path bytes, tracks components and flags broken rules.
module rpv_front #(
  parameter int unsigned SUFFIX_BYTES = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [7:0]                path_byte_i,
  input  logic                      last_i,
  input  logic                      empty_path_i,
  input  logic [63:0]               temp_suffix_i,
  input  logic [rpv_pkg::SufLenW-1:0] suffix_length_i,
  output logic                      push_o,
  output rpv_pkg::job_t             job_o
);

  localparam int unsigned WinW = 8 * SUFFIX_BYTES;
  localparam logic [rpv_pkg::SufLenW-1:0] SufMax = rpv_pkg::SufLenW'(SUFFIX_BYTES);

  logic                      invalid_q, invalid_d;
  logic [rpv_pkg::CntW-1:0]  comp_cnt_q, comp_cnt_d;
  logic [rpv_pkg::CntW-1:0]  path_cnt_q, path_cnt_d;
  logic [1:0]                dots_q, dots_d;
  logic [WinW-1:0]           window_q, window_d;
  logic                      slash_q, slash_d;

  logic [rpv_pkg::SufLenW-1:0] suf_len;
  logic                        is_slash;
  logic                        bad_byte;
  logic [rpv_pkg::CntW-1:0]    cnt_inc;
  logic [1:0]                  dots_new;
  logic [WinW-1:0]             window_new;
  logic                        close_slash;
  logic                        close_last;
  logic                        inv_next;

  // Reserved suffix test on a closing component
  function automatic logic suffix_hit(input logic [rpv_pkg::CntW-1:0] cnt,
                                      input logic [WinW-1:0] win,
                                      input logic [63:0] suffix,
                                      input logic [rpv_pkg::SufLenW-1:0] len);
    logic match;
    match = 1'b1;
    for (int k = 0; k < SUFFIX_BYTES; k++) begin
      if ((rpv_pkg::SufLenW'(k) < len) && (win[8*k +: 8] != suffix[8*k +: 8])) begin
        match = 1'b0;
      end
    end
    if (len == '0) begin
      return 1'b1;
    end
    if (cnt < rpv_pkg::CntW'(len)) begin
      return 1'b0;
    end
    return match;
  endfunction

  // Component rules: lone dot, double dot, reserved suffix
  function automatic logic close_bad(input logic [rpv_pkg::CntW-1:0] cnt,
                                     input logic [1:0] dots,
                                     input logic [WinW-1:0] win,
                                     input logic [63:0] suffix,
                                     input logic [rpv_pkg::SufLenW-1:0] len);
    return ((cnt == rpv_pkg::CntW'(1)) && dots[0])
        || ((cnt == rpv_pkg::CntW'(2)) && (dots == 2'b11))
        || suffix_hit(cnt, win, suffix, len);
  endfunction

  // Clamp suffix length to the window
  assign suf_len = (suffix_length_i > SufMax) ? SufMax : suffix_length_i;

  assign is_slash  = (path_byte_i == rpv_pkg::CH_SLASH);
  assign bad_byte  = (path_byte_i == rpv_pkg::CH_BACKSLASH) || (path_byte_i == rpv_pkg::CH_NUL);
  assign cnt_inc   = (comp_cnt_q == rpv_pkg::CntMax) ? comp_cnt_q
                                                     : comp_cnt_q + rpv_pkg::CntW'(1);
  assign dots_new  = dots_q
                   | {((comp_cnt_q == rpv_pkg::CntW'(1)) && (path_byte_i == rpv_pkg::CH_DOT)),
                      ((comp_cnt_q == '0) && (path_byte_i == rpv_pkg::CH_DOT))};
  assign window_new = WinW'({window_q, path_byte_i});

  assign close_slash = close_bad(comp_cnt_q, dots_q, window_q, temp_suffix_i, suf_len);
  assign close_last  = close_bad(cnt_inc, dots_new, window_new, temp_suffix_i, suf_len);

  // Work out the rule flag after this beat
  always_comb begin
    inv_next = invalid_q | bad_byte;
    if (is_slash) begin
      if ((path_cnt_q == '0) || slash_q) begin
        inv_next = 1'b1;
      end else if (close_slash) begin
        inv_next = 1'b1;
      end
      if (last_i) begin
        inv_next = 1'b1;
      end
    end else if (last_i && close_last) begin
      inv_next = 1'b1;
    end
  end

  // Advance the path state, clear it once a result is handed on
  always_comb begin
    invalid_d  = invalid_q;
    comp_cnt_d = comp_cnt_q;
    path_cnt_d = path_cnt_q;
    dots_d     = dots_q;
    window_d   = window_q;
    slash_d    = slash_q;
    if (accept_i) begin
      if (empty_path_i || last_i) begin
        invalid_d  = 1'b0;
        comp_cnt_d = '0;
        path_cnt_d = '0;
        dots_d     = '0;
        window_d   = '0;
        slash_d    = 1'b0;
      end else begin
        invalid_d  = inv_next;
        path_cnt_d = (path_cnt_q == rpv_pkg::CntMax) ? path_cnt_q
                                                     : path_cnt_q + rpv_pkg::CntW'(1);
        if (is_slash) begin
          comp_cnt_d = '0;
          dots_d     = '0;
          window_d   = '0;
          slash_d    = 1'b1;
        end else begin
          comp_cnt_d = cnt_inc;
          dots_d     = dots_new;
          window_d   = window_new;
          slash_d    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invalid_q  <= 1'b0;
      comp_cnt_q <= '0;
      path_cnt_q <= '0;
      dots_q     <= '0;
      window_q   <= '0;
      slash_q    <= 1'b0;
    end else begin
      invalid_q  <= invalid_d;
      comp_cnt_q <= comp_cnt_d;
      path_cnt_q <= path_cnt_d;
      dots_q     <= dots_d;
      window_q   <= window_d;
      slash_q    <= slash_d;
    end
  end

  // Hand a finished path to the queue
  assign push_o = accept_i && (empty_path_i || last_i);

  always_comb begin
    job_o.empty   = empty_path_i;
    job_o.invalid = empty_path_i ? 1'b0 : inv_next;
    job_o.count   = empty_path_i ? '0
                  : ((path_cnt_q == rpv_pkg::CntMax) ? path_cnt_q
                                                     : path_cnt_q + rpv_pkg::CntW'(1));
  end

endmodule

>>> rtl/rpv_queue.sv
// Short queue of finished paths between front and back.
module rpv_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rpv_pkg::job_t wdata_i,
  input  logic          pop_i,
  output rpv_pkg::job_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (rpv_pkg::QDepth > 1) ? $clog2(rpv_pkg::QDepth) : 1;
  localparam int unsigned CntW = $clog2(rpv_pkg::QDepth + 1);
  localparam logic [CntW-1:0] Depth = CntW'(rpv_pkg::QDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(rpv_pkg::QDepth - 1);

  rpv_pkg::job_t   slots_q [rpv_pkg::QDepth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == Depth);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = slots_q[rptr_q];

  // Advance pointers and fill level
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the incoming entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/rpv_back.sv
// Back end: applies grant, media and length checks and holds the result beat.
module rpv_back #(
  parameter int unsigned MAX_PATH = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rpv_pkg::grant_cfg_t      cfg_i,
  input  logic                     job_valid_i,
  input  rpv_pkg::job_t            job_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic [rpv_pkg::CntW-1:0] built_length_o
);

  localparam logic [rpv_pkg::NeedW-1:0] MaxNeed = rpv_pkg::NeedW'(MAX_PATH);

  logic                      valid_q, valid_d;
  rpv_pkg::status_e          status_q, status_d;
  logic [rpv_pkg::CntW-1:0]  len_q, len_d;

  logic [rpv_pkg::NeedW-1:0] root_w;
  logic [rpv_pkg::NeedW-1:0] cap_w;
  logic [rpv_pkg::NeedW-1:0] need;

  assign root_w = rpv_pkg::NeedW'(cfg_i.root_len);
  assign cap_w  = rpv_pkg::NeedW'(cfg_i.capacity);
  assign need   = root_w + rpv_pkg::NeedW'(job_i.count) + rpv_pkg::NeedW'(2);

  // Take the head entry whenever the output register is free or draining
  assign pop_o = job_valid_i && (!valid_q || !out_stall_i);

  // Decide status in check order
  always_comb begin
    status_d = rpv_pkg::ST_OK;
    len_d    = '0;
    priority if (!cfg_i.granted) begin
      status_d = rpv_pkg::ST_NO_GRANT;
    end else if (cfg_i.media != rpv_pkg::MEDIA_READY) begin
      status_d = rpv_pkg::ST_DISCONNECTED;
    end else if (cfg_i.root_len == '0) begin
      status_d = rpv_pkg::ST_NO_GRANT;
    end else if (job_i.empty) begin
      if (root_w + rpv_pkg::NeedW'(1) > cap_w) begin
        status_d = rpv_pkg::ST_TOO_LONG;
      end else begin
        len_d = rpv_pkg::CntW'(cfg_i.root_len);
      end
    end else if (job_i.invalid) begin
      status_d = rpv_pkg::ST_INVALID;
    end else if ((need > cap_w) || (need > MaxNeed)) begin
      status_d = rpv_pkg::ST_TOO_LONG;
    end else begin
      len_d = rpv_pkg::CntW'(need - rpv_pkg::NeedW'(1));
    end
  end

  // Hold the beat while stalled, drop it once taken
  assign valid_d = pop_o ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= status_d;
      len_q    <= len_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign status_o       = status_q;
  assign built_length_o = len_q;

endmodule

>>> tb/tb.sv
// Self-checking testbench for the relative path validator.
`timescale 1ns / 1ps

module tb;

  localparam int MaxPath      = 256;
  localparam int SuffixBytes  = 8;
  localparam int IdlePercent  = 28;
  localparam int HoldCycles   = 80;
  localparam int SettleCycles = 4;
  localparam int LongPath     = 128;
  localparam int ItemTarget   = 500;
  localparam logic [63:0] SfxTmp = 64'h2e74_6d70;  // ".tmp", final 'p' lowest

  // One beat of the input channel
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } path_beat_t;

  // One result beat as predicted
  typedef struct {
    rpv_pkg::status_e status;
    logic [12:0]      length;
  } path_result_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_index_i   = rpv_pkg::CFG_GRANTED;
  logic [63:0] cfg_wdata_i   = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [7:0]  path_byte_i   = '0;
  logic        last_i        = 1'b0;
  logic        empty_path_i  = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [2:0]  status_o;
  logic [12:0] built_length_o;

  relative_path_validator #(
    .MAX_PATH    (MaxPath),
    .SUFFIX_BYTES(SuffixBytes)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .path_byte_i   (path_byte_i),
    .last_i        (last_i),
    .empty_path_i  (empty_path_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .built_length_o(built_length_o)
  );

  // Predicts the status of each closed path and checks result beats in order
  class path_checker;
    // register copy
    logic             granted;
    logic [1:0]       media;
    logic [6:0]       root_len;
    logic [12:0]      capacity;
    logic [63:0]      sfx_bytes;
    logic [3:0]       sfx_len;
    // state of the path in flight
    logic             bad;
    logic [12:0]      comp_len;
    logic [12:0]      path_len;
    logic [1:0]       dots;
    logic [63:0]      tail;
    logic             after_slash;
    path_result_t     expected_q[$];
    int               failures;
    int               results;
    int               status_count[5];

    function new();
      granted   = 1'b0;
      media     = '0;
      root_len  = '0;
      capacity  = rpv_pkg::CapacityReset;
      sfx_bytes = '0;
      sfx_len   = '0;
      failures  = 0;
      results   = 0;
      foreach (status_count[i]) status_count[i] = 0;
      clear_path();
    endfunction

    function void clear_path();
      bad         = 1'b0;
      comp_len    = '0;
      path_len    = '0;
      dots        = '0;
      tail        = '0;
      after_slash = 1'b0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        rpv_pkg::CFG_GRANTED:    granted   = data[0];
        rpv_pkg::CFG_MEDIA:      media     = data[1:0];
        rpv_pkg::CFG_ROOT_LEN:   root_len  = data[6:0];
        rpv_pkg::CFG_CAPACITY:   capacity  = data[12:0];
        rpv_pkg::CFG_SUFFIX:     sfx_bytes = data;
        rpv_pkg::CFG_SUFFIX_LEN: sfx_len   = data[3:0];
        default: ;
      endcase
    endfunction

    function rpv_pkg::status_e access_status();
      if (!granted) return rpv_pkg::ST_NO_GRANT;
      if (media != rpv_pkg::MEDIA_READY) return rpv_pkg::ST_DISCONNECTED;
      if (root_len == 0) return rpv_pkg::ST_NO_GRANT;
      return rpv_pkg::ST_OK;
    endfunction

    // A zero suffix length reserves every name
    function bit suffix_hit();
      int          n;
      logic [63:0] mask;
      n = (sfx_len > SuffixBytes) ? SuffixBytes : int'(sfx_len);
      if (n == 0) return 1'b1;
      if (comp_len < n) return 1'b0;
      mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
      return (tail & mask) == (sfx_bytes & mask);
    endfunction

    function void end_component();
      if (comp_len == 1 && dots[0]) bad = 1'b1;
      if (comp_len == 2 && dots == 2'b11) bad = 1'b1;
      if (suffix_hit()) bad = 1'b1;
    endfunction

    // Advance the path state by one accepted beat; queue a result on a closing beat
    function void note_beat(logic [7:0] b, logic last, logic empty);
      path_result_t r;
      int           need;
      r.length = '0;
      if (empty) begin
        clear_path();
        r.status = access_status();
        if (r.status == rpv_pkg::ST_OK) begin
          if (int'(root_len) + 1 > int'(capacity)) r.status = rpv_pkg::ST_TOO_LONG;
          else r.length = 13'(root_len);
        end
        expected_q.push_back(r);
        return;
      end
      if (b == rpv_pkg::CH_BACKSLASH || b == rpv_pkg::CH_NUL) bad = 1'b1;
      if (b == rpv_pkg::CH_SLASH) begin
        if (path_len == 0 || after_slash) bad = 1'b1;
        else end_component();
        if (last) bad = 1'b1;
        comp_len    = '0;
        dots        = '0;
        tail        = '0;
        after_slash = 1'b1;
      end else begin
        if (comp_len == 0 && b == rpv_pkg::CH_DOT) dots[0] = 1'b1;
        if (comp_len == 1 && b == rpv_pkg::CH_DOT) dots[1] = 1'b1;
        if (comp_len != rpv_pkg::CntMax) comp_len++;
        tail        = {tail[55:0], b};
        after_slash = 1'b0;
        if (last) end_component();
      end
      if (path_len != rpv_pkg::CntMax) path_len++;
      if (!last) return;
      r.status = access_status();
      if (r.status == rpv_pkg::ST_OK && bad) r.status = rpv_pkg::ST_INVALID;
      if (r.status == rpv_pkg::ST_OK) begin
        need = int'(root_len) + int'(path_len) + 2;
        if (need > int'(capacity) || need > MaxPath) r.status = rpv_pkg::ST_TOO_LONG;
        else r.length = 13'(int'(root_len) + 1 + int'(path_len));
      end
      clear_path();
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [2:0] status, logic [12:0] length);
      path_result_t r;
      if (expected_q.size() == 0) begin
        $error("result beat with no path pending: status %0d built_length %0d",
               status, length);
        failures++;
        return;
      end
      r = expected_q.pop_front();
      results++;
      status_count[int'(r.status)]++;
      if (status !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, status);
        failures++;
      end
      if (length !== r.length) begin
        $error("built_length: expected %0d, actual %0d", r.length, length);
        failures++;
      end
    endfunction
  endclass

  path_checker chk;
  path_beat_t  beats_q[$];
  int          beats_sent    = 0;
  int          random_paths  = 0;
  int          settings_used = 0;
  int          hold_requests = 0;
  int          holds_taken   = 0;
  int          hold_left     = 0;
  bit          calm          = 1'b0;

  // Clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Check result beats and drive the receiver's stall, with a long hold when one is requested
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) chk.check_result(status_o, built_length_o);
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_requests > holds_taken) begin
      holds_taken++;
      hold_left = HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < IdlePercent);
    end
  end

  task automatic push_beat(logic [7:0] data, logic last, logic empty);
    path_beat_t bt;
    bt.data  = data;
    bt.last  = last;
    bt.empty = empty;
    beats_q.push_back(bt);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_beat(s[i], i == s.len() - 1, 1'b0);
  endtask

  // Mostly letters; now and then any nonzero byte that is neither separator; in noisy mode any byte
  function automatic logic [7:0] name_byte(bit noisy);
    logic [7:0] b;
    if (noisy) return 8'($urandom_range(255));
    if ($urandom_range(9) == 0) b = 8'($urandom_range(1, 255));
    else b = 8'($urandom_range(8'h61, 8'h7a));
    if (b == rpv_pkg::CH_SLASH || b == rpv_pkg::CH_BACKSLASH) b = 8'h5f;
    return b;
  endfunction

  // Queue one random path: mostly well formed, some broken, some empty
  task automatic queue_path();
    int         kind;
    int         pick;
    int         ncomp;
    int         clen;
    int         n;
    bit         noisy;
    logic [7:0] body[$];
    kind  = $urandom_range(99);
    noisy = (kind >= 26 && kind < 34);
    if (kind < 8) begin
      // empty path: byte and last carry no meaning
      push_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      return;
    end
    if (kind < 14) begin
      // partial path dropped by an empty path
      n = $urandom_range(1, 6);
      repeat (n) push_beat(name_byte(1'b0), 1'b0, 1'b0);
      push_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      return;
    end
    if (kind < 20) body.push_back(rpv_pkg::CH_SLASH);
    ncomp = $urandom_range(1, 3);
    for (int c = 0; c < ncomp; c++) begin
      if (c > 0) begin
        body.push_back(rpv_pkg::CH_SLASH);
        if ($urandom_range(99) < 5) body.push_back(rpv_pkg::CH_SLASH);
      end
      pick = $urandom_range(99);
      if (pick < 4) begin
        body.push_back(rpv_pkg::CH_DOT);
      end else if (pick < 8) begin
        body.push_back(rpv_pkg::CH_DOT);
        body.push_back(rpv_pkg::CH_DOT);
      end else begin
        clen = $urandom_range(1, 6);
        repeat (clen) body.push_back(name_byte(noisy));
        if ($urandom_range(99) < 15) begin
          n = (chk.sfx_len > SuffixBytes) ? SuffixBytes : int'(chk.sfx_len);
          for (int k = n - 1; k >= 0; k--) body.push_back(chk.sfx_bytes[8 * k +: 8]);
        end
      end
    end
    if (kind >= 20 && kind < 26) body.push_back(rpv_pkg::CH_SLASH);
    foreach (body[i]) push_beat(body[i], i == body.size() - 1, 1'b0);
  endtask

  // Offer one beat, idling at random first, and hold it until accepted
  task automatic send_beat(path_beat_t bt);
    while (!calm && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    path_byte_i  <= bt.data;
    last_i       <= bt.last;
    empty_path_i <= bt.empty;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chk.note_beat(bt.data, bt.last, bt.empty);
    beats_sent++;
  endtask

  task automatic flush_beats();
    while (beats_q.size() != 0) send_beat(beats_q.pop_front());
  endtask

  // Drop valid, drain pending results, then let the pipeline settle
  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (chk.expected_q.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic drive_reg(logic [2:0] idx, logic [63:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    chk.set_reg(idx, data);
  endtask

  task automatic apply_setting(logic g, logic [1:0] m, logic [6:0] root, logic [12:0] cap,
                               logic [63:0] sfx, logic [3:0] slen);
    drive_reg(rpv_pkg::CFG_GRANTED, 64'(g));
    drive_reg(rpv_pkg::CFG_MEDIA, 64'(m));
    drive_reg(rpv_pkg::CFG_ROOT_LEN, 64'(root));
    drive_reg(rpv_pkg::CFG_CAPACITY, 64'(cap));
    drive_reg(rpv_pkg::CFG_SUFFIX, sfx);
    drive_reg(rpv_pkg::CFG_SUFFIX_LEN, 64'(slen));
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(logic g, logic [1:0] m, logic [6:0] root, logic [12:0] cap,
                           logic [63:0] sfx, logic [3:0] slen, int npaths);
    wait_idle();
    apply_setting(g, m, root, cap, sfx, slen);
    repeat (npaths) begin
      queue_path();
      flush_beats();
      random_paths++;
    end
  endtask

  // Stimulus
  initial begin
    int main_paths;
    chk = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers at reset: no grant
    push_beat(8'h00, 1'b1, 1'b1);
    push_text("a");
    flush_beats();
    wait_idle();

    // directed paths under a normal grant
    apply_setting(1'b1, rpv_pkg::MEDIA_READY, 7'd10, 13'd256, SfxTmp, 4'd4);
    push_text("a");
    push_beat(8'h00, 1'b0, 1'b1);
    push_text("/");
    push_text(".");
    push_text("..");
    push_text("a/b");
    push_text("a/");
    push_text("\\");
    push_beat(rpv_pkg::CH_NUL, 1'b1, 1'b0);
    push_text("x.tmp");
    push_beat(8'h61, 1'b0, 1'b0);
    push_beat(8'h62, 1'b0, 1'b0);
    push_beat(8'h00, 1'b1, 1'b1);
    push_beat(8'hff, 1'b1, 1'b0);
    flush_beats();

    // random paths over a spread of register settings
    run_phase(1'b0, rpv_pkg::MEDIA_READY, 7'd10, 13'd256, SfxTmp, 4'd4, 2);
    run_phase(1'b1, 2'd0, 7'd10, 13'd256, SfxTmp, 4'd4, 2);
    run_phase(1'b1, 2'd2, 7'd10, 13'd256, SfxTmp, 4'd4, 2);
    run_phase(1'b1, 2'd3, 7'd10, 13'd256, SfxTmp, 4'd4, 2);
    run_phase(1'b1, rpv_pkg::MEDIA_READY, 7'd0, 13'd256, SfxTmp, 4'd4, 2);
    run_phase(1'b1, rpv_pkg::MEDIA_READY, 7'd10, 13'd0, SfxTmp, 4'd4, 2);
    run_phase(1'b1, rpv_pkg::MEDIA_READY, 7'd10, 13'd11, SfxTmp, 4'd4, 3);
    run_phase(1'b1, rpv_pkg::MEDIA_READY, 7'd5, 13'd20, SfxTmp, 4'd4, 4);
    run_phase(1'b1, rpv_pkg::MEDIA_READY, 7'd127, 13'd8191, '1, 4'd15, 2);
    // one path just past the path limit with a large buffer
    repeat (LongPath - 1) push_beat(8'h61, 1'b0, 1'b0);
    push_beat(8'h61, 1'b1, 1'b0);
    flush_beats();
    run_phase(1'b1, rpv_pkg::MEDIA_READY, 7'd64, 13'd4096, {$urandom, $urandom}, 4'd8, 3);
    run_phase(1'b1, rpv_pkg::MEDIA_READY, 7'd1, 13'd4096, 64'd0, 4'd0, 2);
    run_phase(1'b1, rpv_pkg::MEDIA_READY, 7'd3, 13'd300, 64'h7e, 4'd1, 3);

    // main setting: one long receiver hold, then a stretch with no idling
    wait_idle();
    apply_setting(1'b1, rpv_pkg::MEDIA_READY, 7'd10, 13'd256, SfxTmp, 4'd4);
    hold_requests++;
    main_paths = 0;
    while (main_paths < 16 || beats_sent < ItemTarget) begin
      calm = (main_paths >= 6 && main_paths < 14);
      queue_path();
      flush_beats();
      main_paths++;
      random_paths++;
    end
    calm = 1'b0;

    wait_idle();
    if (chk.expected_q.size() != 0) begin
      $error("%0d results never arrived", chk.expected_q.size());
      chk.failures++;
    end
    $display("Run covered %0d path beats, %0d random paths and %0d register settings.",
             beats_sent, random_paths, settings_used);
    $display("Results checked %0d: ok %0d, no grant %0d, disconnected %0d,",
             chk.results, chk.status_count[rpv_pkg::ST_OK],
             chk.status_count[rpv_pkg::ST_NO_GRANT],
             chk.status_count[rpv_pkg::ST_DISCONNECTED]);
    $display("  invalid %0d, too long %0d",
             chk.status_count[rpv_pkg::ST_INVALID], chk.status_count[rpv_pkg::ST_TOO_LONG]);
    if (chk.failures == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
